@@ hw/rtl/prxe_pkg.sv @@
// ============================================================================
// prxe_pkg
// Shared types and constants of the packed 12bpp pixel and rectangle engine.
// ============================================================================
package prxe_pkg;

    // geometry registers and item field widths
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 16;
    localparam int PIX_W     = 12;

    // pixel store: one 12-bit entry per pixel index, two entries per three bytes
    localparam int MAX_PIXELS = 1048576;
    localparam int PIX_AW     = $clog2(MAX_PIXELS);

    // y*width + x with both factors below 2^CFG_W
    localparam int IDX_W = 2 * CFG_W;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = CFG_W'(800);
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = CFG_W'(600);

    // command codes
    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_code_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    // input item
    typedef struct packed {
        cmd_code_t          command;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [PIX_W-1:0]   color;
    } pixel_item_t;

    // result item
    typedef struct packed {
        logic [PIX_W-1:0] pixel_color;
        logic             status;
    } pixel_result_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic calc_addr;
        logic calc_idx;
        logic wr_pixel;
        logic rd_pixel;
        logic fill_step;
        logic clr_step;
        logic load_rsp;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_code_t command;
        logic      on_screen;
        logic      rect_empty;
        logic      fill_last;
        logic      clr_last;
    } dp_stat_t;

endpackage

@@ hw/rtl/packed_12bpp_pixel_rect_engine.sv @@
// ============================================================================
// packed_12bpp_pixel_rect_engine
// Framebuffer of 12-bit pixels with draw, rectangle fill, clear and read.
// ============================================================================
// After reset the block sweeps the whole pixel store to zero, one pixel a
// cycle, and holds cmd_stall high until the sweep ends; configuration
// writes are taken meanwhile. One item is worked on at a time: a draw or
// read goes from acceptance through address set-up (S_ADDR, then S_IDX),
// the access, then the result register; a fill walks the clipped pixels
// after the same set-up, and a clear sweeps the whole store. The next item
// is accepted in the cycle its predecessor's result is loaded. Pixel x,y
// lives at index y*screen_width + x; an origin off screen reports status 1
// and touches nothing, except that a clear ignores the origin.
module packed_12bpp_pixel_rect_engine
    import prxe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  pixel_item_t          cmd_item,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output pixel_result_t        rsp_item
);

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;

    // sequencer
    prxe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // datapath and pixel store
    prxe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_item  (cmd_item),
        .ctrl      (ctrl),
        .stat      (stat),
        .rsp_item  (rsp_item)
    );

    // an accepted item keeps the input closed in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("input open right after accepting an item");

    // a result is only loaded into a free or draining slot
    a_rsp_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_rsp |-> (!rsp_valid || !rsp_stall))
        else $error("result overwritten while still waiting");

    // one source drives the store write port at a time
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.wr_pixel, ctrl.fill_step, ctrl.clr_step}))
        else $error("store write port has two sources");

    // a new result only follows a result load
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(ctrl.load_rsp))
        else $error("result valid without a load");

endmodule

@@ hw/rtl/prxe_datapath.sv @@
// ============================================================================
// prxe_datapath
// Geometry registers, item and address registers, rectangle walk counters,
// the pixel store and the result register.
// ============================================================================
module prxe_datapath
    import prxe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  pixel_item_t          cmd_item,
    input  ctrl_cmd_t            ctrl,
    output dp_stat_t             stat,
    output pixel_result_t        rsp_item
);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    pixel_item_t       item_reg;
    logic              on_screen_reg;
    logic [CFG_W-1:0]  wclip_reg;
    logic [CFG_W-1:0]  hclip_reg;
    logic [IDX_W-1:0]  prod_reg;
    logic [IDX_W-1:0]  cur_idx_reg;
    logic [IDX_W-1:0]  row_base_reg;
    logic [CFG_W-1:0]  col_cnt_reg;
    logic [CFG_W-1:0]  row_cnt_reg;
    logic [PIX_AW-1:0] clr_cnt_reg;
    logic [PIX_W-1:0]  rd_data_reg;
    pixel_result_t     rsp_reg;

    logic [PIX_W-1:0]  frame_mem [MAX_PIXELS];

    logic              on_screen_next;
    logic [CFG_W-1:0]  span_w;
    logic [CFG_W-1:0]  span_h;
    logic [CFG_W-1:0]  wclip_next;
    logic [CFG_W-1:0]  hclip_next;
    logic [IDX_W-1:0]  prod_next;
    logic [IDX_W-1:0]  start_idx_next;
    logic [IDX_W-1:0]  next_row_base;
    logic              col_last;
    logic              row_last;
    logic              pix_ok;
    logic              mem_we;
    logic [PIX_AW-1:0] mem_waddr;
    logic [PIX_W-1:0]  mem_wdata;

    // geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // origin check, clipping and row offset product
    always_comb
    begin
        on_screen_next = (item_reg.x_pos < COORD_W'(width_reg)) &&
                         (item_reg.y_pos < COORD_W'(height_reg));
        span_w = width_reg - item_reg.x_pos[CFG_W-1:0];
        span_h = height_reg - item_reg.y_pos[CFG_W-1:0];
        wclip_next = (item_reg.rect_width > COORD_W'(span_w)) ?
                     span_w : item_reg.rect_width[CFG_W-1:0];
        hclip_next = (item_reg.rect_height > COORD_W'(span_h)) ?
                     span_h : item_reg.rect_height[CFG_W-1:0];
        prod_next = IDX_W'(item_reg.y_pos[CFG_W-1:0]) * IDX_W'(width_reg);
        start_idx_next = prod_reg + IDX_W'(item_reg.x_pos[CFG_W-1:0]);
        next_row_base = row_base_reg + IDX_W'(width_reg);
    end

    // walk position and store range
    assign col_last = (col_cnt_reg == wclip_reg - CFG_W'(1));
    assign row_last = (row_cnt_reg == hclip_reg - CFG_W'(1));
    assign pix_ok   = (cur_idx_reg < IDX_W'(MAX_PIXELS));

    // item, address and walk registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_reg <= cmd_item;
        end
        if (ctrl.calc_addr)
        begin
            on_screen_reg <= on_screen_next;
            wclip_reg     <= wclip_next;
            hclip_reg     <= hclip_next;
            prod_reg      <= prod_next;
        end
        if (ctrl.calc_idx)
        begin
            cur_idx_reg  <= start_idx_next;
            row_base_reg <= start_idx_next;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
        end
        else if (ctrl.fill_step)
        begin
            if (col_last)
            begin
                col_cnt_reg  <= '0;
                row_cnt_reg  <= row_cnt_reg + CFG_W'(1);
                row_base_reg <= next_row_base;
                cur_idx_reg  <= next_row_base;
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + CFG_W'(1);
                cur_idx_reg <= cur_idx_reg + IDX_W'(1);
            end
        end
    end

    // clear sweep address, wraps back to zero after the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctrl.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + PIX_AW'(1);
        end
    end

    // store write port
    always_comb
    begin
        mem_we    = ctrl.clr_step || ((ctrl.wr_pixel || ctrl.fill_step) && pix_ok);
        mem_waddr = ctrl.clr_step ? clr_cnt_reg : cur_idx_reg[PIX_AW-1:0];
        mem_wdata = ctrl.clr_step ? '0 : item_reg.color;
    end

    // pixel store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (ctrl.rd_pixel)
        begin
            rd_data_reg <= frame_mem[cur_idx_reg[PIX_AW-1:0]];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.load_rsp)
        begin
            rsp_reg.pixel_color <= (item_reg.command == CMD_READ && on_screen_reg && pix_ok) ?
                                   rd_data_reg : '0;
            rsp_reg.status      <= (item_reg.command != CMD_CLEAR) && !on_screen_reg;
        end
    end

    // status to the controller
    always_comb
    begin
        stat.command    = item_reg.command;
        stat.on_screen  = on_screen_reg;
        stat.rect_empty = (wclip_reg == '0) || (hclip_reg == '0);
        stat.fill_last  = col_last && row_last;
        stat.clr_last   = &clr_cnt_reg;
    end

    assign rsp_item = rsp_reg;

endmodule

@@ hw/rtl/prxe_ctrl.sv @@
// ============================================================================
// prxe_ctrl
// Command sequencer: boot clear sweep, address set-up, pixel access,
// rectangle walk, clear sweep and result hand-off.
// ============================================================================
module prxe_ctrl
    import prxe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  dp_stat_t  stat,
    output ctrl_cmd_t ctrl
);

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_ADDR,
        S_IDX,
        S_WRITE,
        S_READ,
        S_FILL,
        S_CLEAR,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   resp_go;
    logic   take;

    // result slot free or draining, and item intake
    always_comb
    begin
        resp_go = (state_reg == S_RESP) && (!rsp_valid_reg || !rsp_stall);
        take    = cmd_valid && ((state_reg == S_IDLE) || resp_go);
    end

    // datapath commands
    always_comb
    begin
        ctrl           = '0;
        ctrl.load_item = take;
        ctrl.calc_addr = (state_reg == S_ADDR);
        ctrl.calc_idx  = (state_reg == S_IDX);
        ctrl.wr_pixel  = (state_reg == S_WRITE);
        ctrl.rd_pixel  = (state_reg == S_READ);
        ctrl.fill_step = (state_reg == S_FILL);
        ctrl.clr_step  = (state_reg == S_BOOT) || (state_reg == S_CLEAR);
        ctrl.load_rsp  = resp_go;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_BOOT:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_IDX;
            end
            S_IDX:
            begin
                if (stat.command == CMD_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else if (!stat.on_screen)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    case (stat.command)
                        CMD_DRAW: state_next = S_WRITE;
                        CMD_READ: state_next = S_READ;
                        CMD_FILL: state_next = stat.rect_empty ? S_RESP : S_FILL;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_WRITE:
            begin
                state_next = S_RESP;
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_FILL:
            begin
                if (stat.fill_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (take)
                begin
                    state_next = S_ADDR;
                end
                else if (resp_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = resp_go || (rsp_valid_reg && rsp_stall);

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_stall = !((state_reg == S_IDLE) || resp_go);
    assign rsp_valid = rsp_valid_reg;

endmodule
